/* design/coo_spmv_pkg.sv */
// ----------------------------------------------------------------------------
// COO sparse matrix-vector multiply package
// Shared sizes, operation codes, register indexes and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package coo_spmv_pkg;

   localparam int VEC_DEPTH = 1024;
   localparam int ADDR_W    = $clog2(VEC_DEPTH);
   localparam int IDX_W     = 10;
   localparam int DATA_W    = 32;
   localparam int ACC_W     = 64;
   localparam int SIZE_W    = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS      = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

   typedef enum logic [1:0] {
      OP_LOAD_X  = 2'd0,
      OP_ACCUM   = 2'd1,
      OP_READ_Y  = 2'd2,
      OP_CLEAR_Y = 2'd3
   } op_type;

   typedef struct packed {
      logic capture;
      logic x_write;
      logic acc_read;
      logic y_read;
      logic mult;
      logic accum;
      logic res_read;
      logic res_err;
      logic res_ok;
      logic sweep;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   in_range;
      logic   sweep_last;
      logic   rsp_free;
   } dp_status_type;

endpackage

/* design/coo_spmv_if.sv */
// ----------------------------------------------------------------------------
// COO sparse matrix-vector multiply channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface coo_spmv_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  opcode;
   logic        [9:0]  row_index;
   logic        [9:0]  col_index;
   logic        [9:0]  vector_index;
   logic signed [31:0] data_value;

   modport source (
      output valid, opcode, row_index, col_index, vector_index, data_value,
      input  ready
   );
   modport sink (
      input  valid, opcode, row_index, col_index, vector_index, data_value,
      output ready
   );
endinterface

interface coo_spmv_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   logic signed [63:0] y_value;

   modport source (
      output valid, status, y_value,
      input  ready
   );
   modport sink (
      input  valid, status, y_value,
      output ready
   );
endinterface

/* design/coo_spmv_ctrl.sv */
// ----------------------------------------------------------------------------
// COO sparse matrix-vector multiply controller
// Sequences one transaction at a time through decode, memory access,
// multiply, accumulate and response, plus the valid-bit clearing sweeps.
// ----------------------------------------------------------------------------
module coo_spmv_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  coo_spmv_pkg::dp_status_type status,
   output coo_spmv_pkg::ctrl_cmd_type  cmd
);
   import coo_spmv_pkg::*;

   typedef enum logic [7:0] {
      S_INIT    = 8'b0000_0001,
      S_IDLE    = 8'b0000_0010,
      S_DECODE  = 8'b0000_0100,
      S_MULT    = 8'b0000_1000,
      S_ACCUM   = 8'b0001_0000,
      S_READ    = 8'b0010_0000,
      S_CLEAR   = 8'b0100_0000,
      S_RESPOND = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            // Valid bits are swept clear after reset before any transaction.
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!status.in_range) begin
               cmd.res_err = 1'b1;
               state_in    = S_RESPOND;
            end else begin
               unique case (status.op)
                  OP_LOAD_X: begin
                     cmd.x_write = 1'b1;
                     cmd.res_ok  = 1'b1;
                     state_in    = S_RESPOND;
                  end
                  OP_ACCUM: begin
                     cmd.acc_read = 1'b1;
                     state_in     = S_MULT;
                  end
                  OP_READ_Y: begin
                     cmd.y_read = 1'b1;
                     state_in   = S_READ;
                  end
                  OP_CLEAR_Y: begin
                     cmd.res_ok = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  default: begin
                     cmd.res_err = 1'b1;
                     state_in    = S_RESPOND;
                  end
               endcase
            end
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum  = 1'b1;
            cmd.res_ok = 1'b1;
            state_in   = S_RESPOND;
         end
         S_READ: begin
            cmd.res_read = 1'b1;
            state_in     = S_RESPOND;
         end
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = S_RESPOND;
            end
         end
         S_RESPOND: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/coo_spmv_dp.sv */
// ----------------------------------------------------------------------------
// COO sparse matrix-vector multiply datapath
// Configuration registers, range checks, x and y memories, the multiplier,
// the saturating accumulator and the response register.
// ----------------------------------------------------------------------------
module coo_spmv_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  coo_spmv_pkg::ctrl_cmd_type             cmd,
   output coo_spmv_pkg::dp_status_type            status,
   input  logic                                   csr_we,
   input  logic [coo_spmv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [coo_spmv_pkg::SIZE_W-1:0]        csr_wdata,
   input  logic [1:0]                             req_opcode,
   input  logic [coo_spmv_pkg::IDX_W-1:0]         req_row_index,
   input  logic [coo_spmv_pkg::IDX_W-1:0]         req_col_index,
   input  logic [coo_spmv_pkg::IDX_W-1:0]         req_vector_index,
   input  logic signed [coo_spmv_pkg::DATA_W-1:0] req_data_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_status,
   output logic signed [coo_spmv_pkg::ACC_W-1:0]  rsp_y_value
);
   import coo_spmv_pkg::*;

   typedef struct packed {
      logic                    valid;
      logic signed [ACC_W-1:0] value;
   } y_entry_type;

   function automatic logic [SIZE_W-1:0] cap_size(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] limit;
      limit = SIZE_W'(VEC_DEPTH);
      return (s > limit) ? limit : s;
   endfunction

   // Configuration registers.
   logic              transpose_ff;
   logic [SIZE_W-1:0] rows_ff;
   logic [SIZE_W-1:0] cols_ff;

   // Captured transaction.
   op_type                   op_ff;
   logic [IDX_W-1:0]         row_ff;
   logic [IDX_W-1:0]         col_ff;
   logic [IDX_W-1:0]         vidx_ff;
   logic signed [DATA_W-1:0] data_ff;

   // Memories and their registered read data.
   logic signed [DATA_W-1:0] x_mem_ff [VEC_DEPTH];
   y_entry_type              y_mem_ff [VEC_DEPTH];
   logic signed [DATA_W-1:0] x_rd_ff;
   y_entry_type              y_rd_ff;

   logic signed [ACC_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] prod_full;

   logic [ADDR_W-1:0] sweep_cnt_ff;
   logic [ADDR_W-1:0] sweep_cnt_in;

   logic                    res_status_ff;
   logic signed [ACC_W-1:0] res_y_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_status_ff;
   logic signed [ACC_W-1:0] rsp_y_ff;

   logic [SIZE_W-1:0] m_size;
   logic [SIZE_W-1:0] n_size;
   logic [SIZE_W-1:0] x_len;
   logic [SIZE_W-1:0] y_len;
   logic              in_range;
   logic [ADDR_W-1:0] dst_addr;
   logic [ADDR_W-1:0] src_addr;
   logic [ADDR_W-1:0] vidx_addr;
   logic [ADDR_W-1:0] y_rd_addr;
   logic [ADDR_W-1:0] y_wr_addr;
   y_entry_type       y_wr_data;
   logic              y_we;

   logic signed [ACC_W-1:0] base;
   logic signed [ACC_W:0]   sum_wide;
   logic signed [ACC_W-1:0] sum_sat;

   assign m_size = cap_size(rows_ff);
   assign n_size = cap_size(cols_ff);
   assign x_len  = transpose_ff ? m_size : n_size;
   assign y_len  = transpose_ff ? n_size : m_size;

   always_comb begin
      unique case (op_ff)
         OP_LOAD_X:  in_range = SIZE_W'(vidx_ff) < x_len;
         OP_ACCUM:   in_range = (SIZE_W'(row_ff) < m_size) && (SIZE_W'(col_ff) < n_size);
         OP_READ_Y:  in_range = SIZE_W'(vidx_ff) < y_len;
         OP_CLEAR_Y: in_range = 1'b1;
         default:    in_range = 1'b0;
      endcase
   end

   // In transpose mode the column picks the y entry and the row the x entry.
   assign dst_addr  = ADDR_W'(transpose_ff ? col_ff : row_ff);
   assign src_addr  = ADDR_W'(transpose_ff ? row_ff : col_ff);
   assign vidx_addr = ADDR_W'(vidx_ff);

   assign status.op         = op_ff;
   assign status.in_range   = in_range;
   assign status.sweep_last = (sweep_cnt_ff == ADDR_W'(VEC_DEPTH - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         transpose_ff <= 1'b0;
         rows_ff      <= SIZE_RESET;
         cols_ff      <= SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRANSPOSE: transpose_ff <= csr_wdata[0];
            CSR_ROWS:      rows_ff      <= csr_wdata;
            CSR_COLS:      cols_ff      <= csr_wdata;
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_opcode);
         row_ff  <= req_row_index;
         col_ff  <= req_col_index;
         vidx_ff <= req_vector_index;
         data_ff <= req_data_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.x_write) begin
         x_mem_ff[vidx_addr] <= data_ff;
      end
      if (cmd.acc_read) begin
         x_rd_ff <= x_mem_ff[src_addr];
      end
   end

   // The y memory is written by the accumulator or by the clearing sweep.
   assign y_rd_addr       = cmd.y_read ? vidx_addr : dst_addr;
   assign y_wr_addr       = cmd.sweep ? sweep_cnt_ff : dst_addr;
   assign y_we            = cmd.sweep || cmd.accum;
   assign y_wr_data.valid = !cmd.sweep;
   assign y_wr_data.value = sum_sat;

   always_ff @(posedge clock) begin
      if (y_we) begin
         y_mem_ff[y_wr_addr] <= y_wr_data;
      end
      if (cmd.y_read || cmd.acc_read) begin
         y_rd_ff <= y_mem_ff[y_rd_addr];
      end
   end

   // Signed 32 by 32 product; both operands are sign-extended to 64 bits.
   assign prod_full = ACC_W'(data_ff) * ACC_W'(x_rd_ff);

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_ff <= prod_full;
      end
   end

   assign base     = y_rd_ff.valid ? y_rd_ff.value : '0;
   assign sum_wide = {base[ACC_W-1], base} + {prod_ff[ACC_W-1], prod_ff};

   // Overflow shows as a disagreement of the two top bits of the wide sum.
   always_comb begin
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[ACC_W-1:0];
      end
   end

   always_comb begin
      sweep_cnt_in = sweep_cnt_ff;
      if (cmd.sweep) begin
         sweep_cnt_in = status.sweep_last ? '0 : sweep_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else begin
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.res_err) begin
         res_status_ff <= 1'b1;
         res_y_ff      <= '0;
      end else if (cmd.res_read) begin
         res_status_ff <= 1'b0;
         res_y_ff      <= y_rd_ff.valid ? y_rd_ff.value : '0;
      end else if (cmd.res_ok) begin
         res_status_ff <= 1'b0;
         res_y_ff      <= '0;
      end
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_y_ff      <= res_y_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_y_value = rsp_y_ff;

endmodule

/* design/sparse_coo_matrix_vector_multiply.sv */
// ----------------------------------------------------------------------------
// Sparse COO matrix-vector multiply: after decode a load or rejected index goes to
// respond, a read through read, an accumulate through multiply and accumulate, a clear
// through the whole sweep; the controller runs one transaction at a time.
// Reset is synchronous; a sweep then clears the y valid bits before ready.
// ----------------------------------------------------------------------------
module sparse_coo_matrix_vector_multiply (
   input  logic                               clock,
   input  logic                               reset,
   coo_spmv_req_if.sink                       req_chan,
   coo_spmv_rsp_if.source                     rsp_chan,
   input  logic                               csr_we,
   input  logic [coo_spmv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [coo_spmv_pkg::SIZE_W-1:0]    csr_wdata
);
   import coo_spmv_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_chan.ready = req_ready;

   coo_spmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   coo_spmv_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_opcode       (req_chan.opcode),
      .req_row_index    (req_chan.row_index),
      .req_col_index    (req_chan.col_index),
      .req_vector_index (req_chan.vector_index),
      .req_data_value   (req_chan.data_value),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_y_value      (rsp_chan.y_value)
   );

endmodule

/* design/coo_spmv_checker.sv */
// ----------------------------------------------------------------------------
// COO sparse matrix-vector multiply port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module coo_spmv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_status,
   input logic [63:0] rsp_y_value
);

   // After reset the block is sweeping and has nothing to deliver.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("ready or response valid right after reset");

   // One transaction at a time: ready drops once a request is taken.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an accepted request");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_y_value == 64'd0)
      else $error("rejected transaction returned a nonzero value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_y_value) && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind sparse_coo_matrix_vector_multiply coo_spmv_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_status  (rsp_chan.status),
   .rsp_y_value (rsp_chan.y_value)
);
